// ===== src/c2dsp_pkg.sv =====
// shared constants, codes and command/status types of the padded-window convolver
`timescale 1ns / 1ps
package c2dsp_pkg;

	// default sizing of the block
	localparam int DEF_MAX_KERNEL = 9;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// field widths
	localparam int COEF_IDX_W = 7;
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 40;
	localparam int OUT_POS_W  = 10;
	localparam int PROD_W     = 2 * SAMPLE_W;

	// configuration registers
	localparam int KSIZE_W   = 4;
	localparam int IMG_DIM_W = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;

	localparam logic [KSIZE_W-1:0]   KSIZE_RST  = KSIZE_W'(3);
	localparam logic [IMG_DIM_W-1:0] WIDTH_RST  = IMG_DIM_W'(1024);
	localparam logic [IMG_DIM_W-1:0] HEIGHT_RST = IMG_DIM_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KSIZE  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	// item commands
	localparam logic CMD_COEF  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic take;     // input transaction accepted
		logic step;     // issue one tap read
		logic load_out; // move window sum to output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic win_hit;    // current pixel completes an in-range window
		logic issue_last; // tap read being issued is the last of the window
		logic pipe_busy;  // multiply/accumulate pipe still holds taps
		logic out_free;   // output register can take a new result
	} dp_sts_t;

endpackage

// ===== src/c2dsp_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module c2dsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/c2dsp_ctrl.sv =====
// controller state machine: accept, tap issue, drain and result hand-off
`timescale 1ns / 1ps
module c2dsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  c2dsp_pkg::dp_sts_t sts,
	output c2dsp_pkg::dp_cmd_t dcmd
);
	import c2dsp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   take;

	assign in_stall = (state_q != ST_IDLE);
	assign take     = in_valid && !in_stall;

	always_comb begin
		dcmd.take     = take;
		dcmd.step     = (state_q == ST_RUN);
		dcmd.load_out = (state_q == ST_DRAIN) && !sts.pipe_busy && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take && sts.win_hit) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (sts.issue_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!sts.pipe_busy && sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_run_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && sts.issue_last) |=> state_q == ST_DRAIN)
		else $error("last tap issued but controller did not drain");

	a_hit_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(take && sts.win_hit) |=> (state_q == ST_RUN && in_stall))
		else $error("window hit did not start tap issue");

endmodule

// ===== src/c2dsp_dp.sv =====
// datapath: config regs, position counters, line buffer, kernel store, mac, output reg
`timescale 1ns / 1ps
module c2dsp_dp #(
	parameter int MAX_KERNEL = c2dsp_pkg::DEF_MAX_KERNEL,
	parameter int MAX_WIDTH  = c2dsp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = c2dsp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [c2dsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [c2dsp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                  cmd,
	input  logic [c2dsp_pkg::COEF_IDX_W-1:0]      coef_index,
	input  logic signed [c2dsp_pkg::SAMPLE_W-1:0] sample_value,
	input  c2dsp_pkg::dp_cmd_t                    dcmd,
	output c2dsp_pkg::dp_sts_t                    sts,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [c2dsp_pkg::SUM_W-1:0]    window_sum,
	output logic [c2dsp_pkg::OUT_POS_W-1:0]       out_col,
	output logic [c2dsp_pkg::OUT_POS_W-1:0]       out_row,
	output logic                                  frame_last
);
	import c2dsp_pkg::*;

	localparam int P_MAX  = MAX_KERNEL / 2;
	localparam int STRIDE = MAX_WIDTH + 2 * P_MAX;
	localparam int RDEPTH = MAX_KERNEL * STRIDE;
	localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int RA_W   = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
	localparam int KA_W   = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
	localparam int KW_W   = $clog2(MAX_KERNEL + 1);
	localparam int CW     = $clog2(STRIDE + 1);
	localparam int RW     = $clog2(MAX_HEIGHT + 2 * P_MAX + 1);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);

	// configuration registers
	logic [KSIZE_W-1:0]   ksize_q;
	logic [IMG_DIM_W-1:0] width_q;
	logic [IMG_DIM_W-1:0] height_q;

	// effective sizes
	logic [KW_W-1:0] k_eff;
	logic [KW_W-1:0] p_eff;
	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic [CW-1:0]   wp;
	logic [RW-1:0]   hp;

	// input position
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [KW_W-1:0] wslot_q;
	logic [RA_W-1:0] wbase_q;
	logic            restart;
	logic [CW-1:0]   col;
	logic [RW-1:0]   row;
	logic [KW_W-1:0] cur_slot;
	logic [RA_W-1:0] cur_base;
	logic [CW-1:0]   col_p1;
	logic [RW-1:0]   row_p1;
	logic [CW-1:0]   ox;
	logic [RW-1:0]   oy;
	logic            slot_top;
	logic            pix_take;

	// window walk
	logic [CW-1:0]   ox_q;
	logic [RW-1:0]   oy_q;
	logic            last_q;
	logic [RA_W-1:0] rbase_q;
	logic [KW_W-1:0] rslot_q;
	logic [RA_W-1:0] rcol_q;
	logic [KW_W-1:0] kx_q;
	logic [KW_W-1:0] ky_q;
	logic [KA_W-1:0] kidx_q;

	// mac pipe
	logic                       rd_v_s1;
	logic                       prod_v_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [SUM_W-1:0]    acc_q;
	logic [SAMPLE_W-1:0]        pix_rdata;
	logic [SAMPLE_W-1:0]        coef_rdata;
	logic                       coef_we;
	logic                       out_valid_q;

	always_comb begin
		if (ksize_q == '0) k_eff = KW_W'(1);
		else if (32'(ksize_q) > MAX_KERNEL) k_eff = KW_W'(MAX_KERNEL);
		else k_eff = KW_W'(ksize_q);
		if (width_q == '0) w_eff = WW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(width_q);
		if (height_q == '0) h_eff = HW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(height_q);
	end

	assign p_eff = k_eff >> 1;
	assign wp    = CW'(w_eff) + (CW'(p_eff) << 1);
	assign hp    = RW'(h_eff) + (RW'(p_eff) << 1);

	assign restart  = (col_q >= wp) || (row_q >= hp);
	assign col      = restart ? '0 : col_q;
	assign row      = restart ? '0 : row_q;
	assign cur_slot = restart ? '0 : wslot_q;
	assign cur_base = restart ? '0 : wbase_q;
	assign col_p1   = col + CW'(1);
	assign row_p1   = row + RW'(1);
	assign ox       = col_p1 - CW'(k_eff);
	assign oy       = row_p1 - RW'(k_eff);
	assign slot_top = (cur_slot == k_eff - KW_W'(1));
	assign pix_take = dcmd.take && (cmd == CMD_PIXEL);
	assign coef_we  = dcmd.take && (cmd == CMD_COEF) && (32'(coef_index) < KDEPTH);

	always_comb begin
		sts.win_hit = (cmd == CMD_PIXEL) && (col_p1 >= CW'(k_eff)) && (row_p1 >= RW'(k_eff))
			&& (ox < CW'(w_eff)) && (oy < RW'(h_eff));
		sts.issue_last = (kx_q == k_eff - KW_W'(1)) && (ky_q == k_eff - KW_W'(1));
		sts.pipe_busy  = rd_v_s1 || prod_v_s2;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// config and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q  <= KSIZE_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
			wslot_q  <= '0;
			wbase_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KSIZE:  ksize_q  <= KSIZE_W'(cfg_data);
				REG_WIDTH:  width_q  <= IMG_DIM_W'(cfg_data);
				REG_HEIGHT: height_q <= IMG_DIM_W'(cfg_data);
				default: ;
			endcase
			if (cfg_index == REG_KSIZE || cfg_index == REG_WIDTH
				|| cfg_index == REG_HEIGHT) begin
				col_q   <= '0;
				row_q   <= '0;
				wslot_q <= '0;
				wbase_q <= '0;
			end
		end else if (pix_take) begin
			if (col_p1 >= wp) begin
				col_q <= '0;
				if (row_p1 >= hp) begin
					row_q   <= '0;
					wslot_q <= '0;
					wbase_q <= '0;
				end else begin
					row_q   <= row_p1;
					wslot_q <= slot_top ? '0 : cur_slot + KW_W'(1);
					wbase_q <= slot_top ? '0 : cur_base + RA_W'(STRIDE);
				end
			end else begin
				col_q   <= col_p1;
				row_q   <= row;
				wslot_q <= cur_slot;
				wbase_q <= cur_base;
			end
		end
	end

	// window walk over the kernel
	always_ff @(posedge clk) begin
		if (pix_take && sts.win_hit) begin
			ox_q    <= ox;
			oy_q    <= oy;
			last_q  <= (ox == CW'(w_eff) - CW'(1)) && (oy == RW'(h_eff) - RW'(1));
			rslot_q <= slot_top ? '0 : cur_slot + KW_W'(1);
			rbase_q <= slot_top ? '0 : cur_base + RA_W'(STRIDE);
			rcol_q  <= RA_W'(ox);
			kx_q    <= '0;
			ky_q    <= '0;
			kidx_q  <= '0;
		end else if (dcmd.step) begin
			kidx_q <= kidx_q + KA_W'(1);
			if (kx_q == k_eff - KW_W'(1)) begin
				kx_q    <= '0;
				ky_q    <= ky_q + KW_W'(1);
				rcol_q  <= RA_W'(ox_q);
				rslot_q <= (rslot_q == k_eff - KW_W'(1)) ? '0 : rslot_q + KW_W'(1);
				rbase_q <= (rslot_q == k_eff - KW_W'(1)) ? '0 : rbase_q + RA_W'(STRIDE);
			end else begin
				kx_q   <= kx_q + KW_W'(1);
				rcol_q <= rcol_q + RA_W'(1);
			end
		end
	end

	c2dsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(RDEPTH), .AW(RA_W)) u_line_ram (
		.clk   (clk),
		.we    (pix_take),
		.waddr (cur_base + RA_W'(col)),
		.wdata (sample_value),
		.raddr (rbase_q + rcol_q),
		.rdata (pix_rdata)
	);

	c2dsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(KDEPTH), .AW(KA_W)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (KA_W'(coef_index)),
		.wdata (sample_value),
		.raddr (kidx_q),
		.rdata (coef_rdata)
	);

	// multiply then accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1     <= 1'b0;
			prod_v_s2   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1   <= dcmd.step;
			prod_v_s2 <= rd_v_s1;
			if (dcmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) prod_s2 <= $signed(pix_rdata) * $signed(coef_rdata);
		if (pix_take && sts.win_hit) acc_q <= '0;
		else if (prod_v_s2) acc_q <= acc_q + SUM_W'(prod_s2);
		if (dcmd.load_out) begin
			window_sum <= acc_q;
			out_col    <= OUT_POS_W'(ox_q);
			out_row    <= OUT_POS_W'(oy_q);
			frame_last <= last_q;
		end
	end

	assign out_valid = out_valid_q;

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending transaction");

	a_load_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.load_out |-> (!rd_v_s1 && !prod_v_s2 && !dcmd.step))
		else $error("result loaded while taps in flight");

endmodule

// ===== src/conv2d_same_padded_window.sv =====
// top level of the streaming KxK same-padded convolver
`timescale 1ns / 1ps
// Streaming KxK correlation over a pre-padded image, giving a WxH output. Send
// cmd=0 transactions to load every coefficient (index ky*K+kx, Q2.14), then the
// (W+2p)x(H+2p) padded image in raster order with cmd=1, p=K/2. Each pixel that
// completes a window yields one result carrying the 40-bit Q.14 sum, the output
// column and row, and frame_last on the final output pixel. A coefficient
// transaction, and a pixel that completes no window, do not raise in_stall. A
// pixel that completes a window holds in_stall while the taps come one per cycle
// from the line buffer memory's single read port into one multiplier, through
// the read and multiply registers, and until the sum is loaded into the output
// register once that register is free. The output register frees the input
// side while a finished result waits to be taken. Any write of a configuration
// register restarts the frame position; coefficients and buffered lines are
// kept. Write registers only while the block is idle.
module conv2d_same_padded_window #(
	parameter int MAX_KERNEL = c2dsp_pkg::DEF_MAX_KERNEL,
	parameter int MAX_WIDTH  = c2dsp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = c2dsp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [c2dsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [c2dsp_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  cmd,
	input  logic [c2dsp_pkg::COEF_IDX_W-1:0]      coef_index,
	input  logic signed [c2dsp_pkg::SAMPLE_W-1:0] sample_value,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [c2dsp_pkg::SUM_W-1:0]    window_sum,
	output logic [c2dsp_pkg::OUT_POS_W-1:0]       out_col,
	output logic [c2dsp_pkg::OUT_POS_W-1:0]       out_row,
	output logic                                  frame_last
);
	import c2dsp_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t dcmd;
	dp_sts_t sts;

	// controller: accepts transactions, sequences tap reads, hands off results
	c2dsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.dcmd     (dcmd)
	);

	// datapath: line buffer, kernel store, multiply-accumulate, output register
	c2dsp_dp #(
		.MAX_KERNEL (MAX_KERNEL),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.coef_index   (coef_index),
		.sample_value (sample_value),
		.dcmd         (dcmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.window_sum   (window_sum),
		.out_col      (out_col),
		.out_row      (out_row),
		.frame_last   (frame_last)
	);

endmodule
